FILE: rtl/zrv_pkg.sv
// Shared types and constants for the zero-run varint encoder.
// No dependencies; imported by the shifter and the top level.
package zrv_pkg;

   localparam int DeltaBits     = 64;
   localparam int GroupBits     = 7;
   localparam int RunCountWidth = 32;
   // count - 1 must fit in five varint bytes
   localparam int CountBits     = (RunCountWidth > 35) ? 35 : RunCountWidth;
   localparam logic [CountBits-1:0] CountMax = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK,
      ST_RUN,
      ST_DELTA
   } state_type;

   typedef struct packed {
      logic                 load;
      logic                 shift;
      logic [DeltaBits-1:0] value;
   } shift_ctl_type;

   typedef struct packed {
      logic [GroupBits-1:0] group;
      logic                 last;
   } shift_sts_type;

endpackage

FILE: rtl/zrv_shifter.sv
// Shared varint shift unit: holds the value being encoded, 7 bits per step.
// Depends on zrv_pkg.
module zrv_shifter (
   input  logic                   clock,
   input  zrv_pkg::shift_ctl_type ctl,
   output zrv_pkg::shift_sts_type sts
);
   import zrv_pkg::*;

   logic [DeltaBits-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         value_ff <= ctl.value;
      end else if (ctl.shift) begin
         value_ff <= value_ff >> GroupBits;
      end
   end

   assign sts.group = value_ff[GroupBits-1:0];
   assign sts.last  = (value_ff[DeltaBits-1:GroupBits] == '0);

endmodule

FILE: rtl/zero_run_varint_encoder.sv
// Zero-run varint encoder: one request (a signed 64-bit delta) becomes 0 to 16
// bytes, one byte per cycle while rsp_tready is high, from a single 7-bit
// shift unit. A pending run adds the zero marker and 1 to 5 count bytes, a
// delta 1 to 10 bytes; req_tready is low until the last byte has been taken.
// A zero delta with runs enabled and no end-of-chunk only bumps the run count
// and produces no byte.
// Depends on zrv_pkg and zrv_shifter.
module zero_run_varint_encoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wen,
   input  logic        csr_wdata,     // zero_runs_enable
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,     // [63:0] delta
   input  logic        req_tlast,     // end_of_chunk
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // [7:0] byte_out
   output logic        rsp_tlast,     // last_of_item
   output logic        rsp_tuser      // [0] chunk_done
);
   import zrv_pkg::*;

   state_type            state_ff, state_in;
   logic [DeltaBits-1:0] delta_ff, delta_in;
   logic                 eoc_ff, eoc_in;
   logic                 wdelta_ff, wdelta_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic                 enable_ff;

   shift_ctl_type ctl;
   shift_sts_type sts;

   logic                 req_accept, rsp_accept;
   logic                 write_delta;
   logic [CountBits-1:0] count_nxt;
   logic                 do_flush;

   zrv_shifter u_shifter (
      .clock (clock),
      .ctl   (ctl),
      .sts   (sts)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (state_ff != ST_IDLE);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   assign write_delta = (req_tdata != '0) || !enable_ff;
   assign count_nxt   = (write_delta || count_ff == CountMax) ? count_ff
                                                              : count_ff + CountBits'(1);
   assign do_flush    = (count_nxt != '0) && (write_delta || req_tlast);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         enable_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_wen) begin
            enable_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      delta_ff  <= delta_in;
      eoc_ff    <= eoc_in;
      wdelta_ff <= wdelta_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      delta_in  = delta_ff;
      eoc_in    = eoc_ff;
      wdelta_in = wdelta_ff;
      ctl.load  = 1'b0;
      ctl.shift = 1'b0;
      ctl.value = delta_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               delta_in  = req_tdata;
               eoc_in    = req_tlast;
               wdelta_in = write_delta;
               count_in  = count_nxt;
               if (do_flush) begin
                  state_in  = ST_MARK;
                  ctl.load  = 1'b1;
                  ctl.value = '0;
               end else if (write_delta) begin
                  state_in  = ST_DELTA;
                  ctl.load  = 1'b1;
                  ctl.value = req_tdata;
               end
            end
         end
         ST_MARK: begin
            if (rsp_accept) begin
               state_in  = ST_RUN;
               ctl.load  = 1'b1;
               ctl.value = {{(DeltaBits-CountBits){1'b0}}, count_ff - CountBits'(1)};
            end
         end
         ST_RUN: begin
            if (rsp_accept) begin
               if (sts.last) begin
                  count_in = '0;
                  if (wdelta_ff) begin
                     state_in  = ST_DELTA;
                     ctl.load  = 1'b1;
                     ctl.value = delta_ff;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  ctl.shift = 1'b1;
               end
            end
         end
         ST_DELTA: begin
            if (rsp_accept) begin
               if (sts.last) begin
                  state_in = ST_IDLE;
               end else begin
                  ctl.shift = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_tdata = {!sts.last, sts.group};
   assign rsp_tlast = sts.last &&
                      (state_ff == ST_DELTA || (state_ff == ST_RUN && !wdelta_ff));
   assign rsp_tuser = rsp_tlast && eoc_ff;

   a_chunk_needs_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("chunk_done without last_of_item");

   a_mark_is_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> rsp_tdata == 8'h00)
      else $error("zero marker byte not zero");

   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN && rsp_accept && sts.last |=> count_ff == '0)
      else $error("run count not cleared after flush");

   a_flush_pending: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tlast |=> rsp_tvalid && count_ff == $past(count_nxt))
      else $error("end of chunk produced no bytes");

endmodule
